@@ rtl/core/tsm_pkg.sv @@
// Shared types and constants for the track hit segment merger.
`default_nettype none

package tsm_pkg;

  // Field and state widths
  localparam int unsigned IN_W  = 24;  // energy_loss and step_length
  localparam int unsigned POS_W = 40;  // track position and segmented distance
  localparam int unsigned ACC_W = 32;  // collected sums and result fields
  localparam int unsigned CNT8_W = 8;  // hit counter and group size
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HITS_PER_GROUP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CATCH_REMAINING = 2'd3;

  // Reset values of the configuration registers
  localparam logic [IN_W-1:0]   SEG_LEN_RESET   = 24'd5000;
  localparam logic [CNT8_W-1:0] GROUP_RESET     = 8'd4;

  // Merge modes
  typedef enum logic [MODE_W-1:0] {
    MODE_FIXED_SEG = 2'd0,
    MODE_HIT_COUNT = 2'd1,
    MODE_MAX_DX    = 2'd2,
    MODE_MIN_DX    = 2'd3
  } merge_mode_t;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    EMIT_NONE     = 2'd0,
    EMIT_BOUNDARY = 2'd1,
    EMIT_GROUP    = 2'd2,
    EMIT_FLUSH    = 2'd3
  } emit_kind_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_BOUND,
    S_BADV,
    S_GROUP,
    S_MIN,
    S_COLLECT,
    S_END
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;        // take the input item, advance track position
    logic       collect;     // add the held hit into the collector
    logic       clear;       // empty the collector
    logic       div_start;   // start boundary count division
    logic       sd_add_len;  // segmented distance += collected length
    logic       sd_add_seg;  // segmented distance += segment length
    logic       sd_add_adv;  // segmented distance += crossings * segment length
    logic       end_clear;   // track end: clear position, distance, collector
    emit_kind_t emit;        // result to load into the output register
    logic       emit_last;   // result is the last one of this item
  } tsm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    merge_mode_t mode;
    logic        eot;
    logic        flush_wanted;
    logic        d_zero;      // track position not past segmented distance
    logic        cond_max;    // position >= threshold
    logic        cond_min;    // position > threshold
    logic        group_hit;   // hit counter reached group size
    logic        nonempty;
    logic        div_done;
    logic        cross_nz;    // at least one boundary crossed
    logic        rem_zero;    // no boundary results left
    logic        rem_one;     // one boundary result left
    logic        out_free;    // output register can take a result
  } tsm_status_t;

endpackage

`default_nettype wire

@@ rtl/core/track_hit_segment_merger.sv @@
// Top level: joins controller and datapath.
// One item in work at a time. Hit-count, max-dx and min-dx items pass S_DECIDE, a mode state
// and S_END; fixed mode goes from S_DECIDE to S_END while the track is not past the
// handed-out distance. Otherwise a 40-step serial divider counts the crossings, and S_BOUND
// then gives one boundary result per cycle while m_tready does not stall the output.
// Stalls on m_tready lengthen an item. Sync active-high reset: idle, output empty, state clear.
`default_nettype none

module track_hit_segment_merger
  import tsm_pkg::*;
#(
  parameter int unsigned MAX_RESULTS_PER_HIT = 64
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // hit input
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [2*IN_W-1:0]     s_tdata,   // energy_loss, step_length
  input  wire logic                  s_tlast,   // end_of_track
  // merged result output
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [2*ACC_W-1:0]         m_tdata,   // merged_energy, merged_length
  output logic                       m_tlast,   // last_of_run
  output logic [1:0]                 m_tuser    // flush_result, truncated
);

  tsm_cmd_t    cmd;
  tsm_status_t status;

  tsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tsm_datapath #(
    .MAX_RESULTS_PER_HIT (MAX_RESULTS_PER_HIT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

@@ rtl/core/tsm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the boundary count.
`default_nettype none

module tsm_div
  import tsm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [POS_W-1:0] dividend,
  input  wire logic [IN_W-1:0]  divisor,
  output logic                  done,
  output logic [POS_W-1:0]      quotient,
  output logic [IN_W-1:0]       remainder
);

  localparam int unsigned STEP_W = $clog2(POS_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [IN_W-1:0]   dvs;
  logic [IN_W:0]     shifted;
  logic              fits;

  // Partial remainder with the next dividend bit shifted in
  assign shifted = {remainder, quotient[POS_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // Control: busy flag, step count, one-cycle done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      done <= 1'b0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(POS_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: quotient shifts in from the bottom as the dividend leaves the top
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= IN_W'(shifted - {1'b0, dvs});
      end else begin
        remainder <= shifted[IN_W-1:0];
      end
      quotient <= {quotient[POS_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tsm_datapath.sv @@
// Datapath: configuration, track state, collector, boundary counting, output register.
`default_nettype none

module tsm_datapath
  import tsm_pkg::*;
#(
  parameter int unsigned MAX_RESULTS_PER_HIT = 64
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input payload
  input  wire logic [2*IN_W-1:0]     s_tdata,
  input  wire logic                  s_tlast,
  // output channel
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [2*ACC_W-1:0]         m_tdata,
  output logic                       m_tlast,
  output logic [1:0]                 m_tuser,
  // controller link
  input  wire tsm_cmd_t              cmd,
  output tsm_status_t                status
);

  localparam int unsigned CNT_W = $clog2(MAX_RESULTS_PER_HIT + 1);

  // Configuration registers
  merge_mode_t       mode;
  logic [IN_W-1:0]   seg_len;
  logic [CNT8_W-1:0] group_size;
  logic              catch_rem;

  // Held item
  logic [IN_W-1:0] hit_e;
  logic [IN_W-1:0] hit_dx;
  logic            hit_eot;

  // Track and collector state
  logic [POS_W-1:0]  track_position;
  logic [POS_W-1:0]  segmented_distance;
  logic [ACC_W-1:0]  energy_accumulator;
  logic [ACC_W-1:0]  length_accumulator;
  logic [CNT8_W-1:0] hit_counter;
  logic              collector_nonempty;

  // Boundary counting
  logic [POS_W-1:0] dist_m1;
  logic [POS_W-1:0] advance;
  logic [CNT_W-1:0] remaining;
  logic             dropped;
  logic             first;
  logic             cross_nz;
  logic             div_done;
  logic [POS_W-1:0] div_q;
  logic [IN_W-1:0]  div_r;
  logic [CNT_W-1:0] cap;

  // Derived values
  logic [IN_W-1:0]   seg_eff;
  logic [CNT8_W-1:0] group_eff;
  logic              flush_wanted;
  logic [POS_W:0]    tp_sum;
  logic [POS_W:0]    threshold;
  logic [POS_W:0]    sd_len_sum;
  logic [POS_W:0]    sd_seg_sum;
  logic [POS_W:0]    sd_adv_sum;
  logic [ACC_W:0]    e_sum;
  logic [ACC_W:0]    l_sum;
  logic              out_free;
  logic [ACC_W-1:0]  out_e;
  logic [ACC_W-1:0]  out_l;

  assign seg_eff      = (seg_len == '0) ? IN_W'(1) : seg_len;
  assign group_eff    = (group_size == '0) ? CNT8_W'(1) : group_size;
  assign flush_wanted = hit_eot & catch_rem;
  assign tp_sum       = {1'b0, track_position} + (POS_W+1)'(s_tdata[2*IN_W-1:IN_W]);
  assign threshold    = {1'b0, segmented_distance} + (POS_W+1)'(seg_eff);
  assign sd_len_sum   = {1'b0, segmented_distance} + (POS_W+1)'(length_accumulator);
  assign sd_seg_sum   = {1'b0, segmented_distance} + (POS_W+1)'(seg_eff);
  assign sd_adv_sum   = {1'b0, segmented_distance} + {1'b0, advance};
  assign e_sum        = {1'b0, energy_accumulator} + (ACC_W+1)'(hit_e);
  assign l_sum        = {1'b0, length_accumulator} + (ACC_W+1)'(hit_dx);
  assign cap          = CNT_W'(MAX_RESULTS_PER_HIT) - CNT_W'(flush_wanted);
  assign out_free     = ~m_tvalid | m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_FIXED_SEG;
      seg_len    <= SEG_LEN_RESET;
      group_size <= GROUP_RESET;
      catch_rem  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MERGE_MODE:      mode       <= merge_mode_t'(cfg_data[MODE_W-1:0]);
        REG_SEGMENT_LENGTH:  seg_len    <= cfg_data[IN_W-1:0];
        REG_HITS_PER_GROUP:  group_size <= cfg_data[CNT8_W-1:0];
        REG_CATCH_REMAINING: catch_rem  <= cfg_data[0];
        default:             mode       <= mode;
      endcase
    end
  end

  // Held item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_e   <= s_tdata[IN_W-1:0];
      hit_dx  <= s_tdata[2*IN_W-1:IN_W];
      hit_eot <= s_tlast;
    end
  end

  // Track position: saturating sum of step lengths
  always_ff @(posedge clk) begin
    if (rst || cmd.end_clear) begin
      track_position <= '0;
    end else if (cmd.load) begin
      track_position <= tp_sum[POS_W] ? '1 : tp_sum[POS_W-1:0];
    end
  end

  // Segmented distance
  always_ff @(posedge clk) begin
    if (rst || cmd.end_clear) begin
      segmented_distance <= '0;
    end else if (cmd.sd_add_len) begin
      segmented_distance <= sd_len_sum[POS_W] ? '1 : sd_len_sum[POS_W-1:0];
    end else if (cmd.sd_add_seg) begin
      segmented_distance <= sd_seg_sum[POS_W] ? '1 : sd_seg_sum[POS_W-1:0];
    end else if (cmd.sd_add_adv) begin
      segmented_distance <= sd_adv_sum[POS_W] ? '1 : sd_adv_sum[POS_W-1:0];
    end
  end

  // Collector
  always_ff @(posedge clk) begin
    if (rst || cmd.end_clear || cmd.clear) begin
      energy_accumulator <= '0;
      length_accumulator <= '0;
      hit_counter        <= '0;
      collector_nonempty <= 1'b0;
    end else if (cmd.collect) begin
      energy_accumulator <= e_sum[ACC_W] ? '1 : e_sum[ACC_W-1:0];
      length_accumulator <= l_sum[ACC_W] ? '1 : l_sum[ACC_W-1:0];
      if (hit_counter != '1) begin
        hit_counter <= hit_counter + 1'b1;
      end
      collector_nonempty <= 1'b1;
    end
  end

  // Boundary count: divide (distance - 1) by the segment length
  tsm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dist_m1),
    .divisor   (seg_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // track_position - segmented_distance - 1, used only when the position is ahead
  assign dist_m1 = track_position + ~segmented_distance;

  // Distance covered by the crossed segments: (d - 1) - remainder
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // hold the dividend for the advance
      advance <= dist_m1;
    end else if (div_done) begin
      advance <= advance - POS_W'(div_r);
    end
  end

  // Boundary result bookkeeping
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      remaining <= '0;
      dropped   <= 1'b0;
      first     <= 1'b1;
      cross_nz  <= 1'b0;
    end else if (div_done) begin
      remaining <= (div_q > POS_W'(cap)) ? cap : div_q[CNT_W-1:0];
      dropped   <= div_q > POS_W'(cap);
      cross_nz  <= div_q != '0;
    end else if (cmd.emit == EMIT_BOUNDARY) begin
      remaining <= remaining - 1'b1;
      first     <= 1'b0;
    end
  end

  // Result fields by kind
  always_comb begin
    unique case (cmd.emit)
      EMIT_BOUNDARY: begin
        out_e = first ? energy_accumulator : '0;
        out_l = ACC_W'(seg_eff);
      end
      EMIT_FLUSH: begin
        out_e = energy_accumulator;
        out_l = (mode == MODE_FIXED_SEG) ? ACC_W'(seg_eff) : length_accumulator;
      end
      EMIT_GROUP: begin
        out_e = energy_accumulator;
        out_l = length_accumulator;
      end
      default: begin
        out_e = energy_accumulator;
        out_l = length_accumulator;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      m_tdata <= {out_l, out_e};
      m_tlast <= cmd.emit_last;
      m_tuser <= {cmd.emit_last & dropped, cmd.emit == EMIT_FLUSH};
    end
  end

  // Status to the controller
  always_comb begin
    status.mode         = mode;
    status.eot          = hit_eot;
    status.flush_wanted = flush_wanted;
    status.d_zero       = track_position <= segmented_distance;
    status.cond_max     = {1'b0, track_position} >= threshold;
    status.cond_min     = {1'b0, track_position} > threshold;
    status.group_hit    = hit_counter >= group_eff;
    status.nonempty     = collector_nonempty;
    status.div_done     = div_done;
    status.cross_nz     = cross_nz;
    status.rem_zero     = remaining == '0;
    status.rem_one      = remaining == CNT_W'(1);
    status.out_free     = out_free;
  end

endmodule

`default_nettype wire

@@ rtl/core/tsm_ctrl.sv @@
// Controller: sequences one item through the merge steps of the selected mode.
`default_nettype none

module tsm_ctrl
  import tsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire tsm_status_t status,
  output tsm_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (status.mode)
          MODE_FIXED_SEG: state_next = status.d_zero ? S_END : S_DIV;
          MODE_HIT_COUNT: state_next = S_GROUP;
          MODE_MAX_DX: begin
            if (!(status.cond_max && status.nonempty) || status.out_free) begin
              state_next = S_COLLECT;
            end
          end
          MODE_MIN_DX:    state_next = S_MIN;
          default:        state_next = S_END;
        endcase
      end
      S_DIV: begin
        if (status.div_done) state_next = S_BOUND;
      end
      S_BOUND: begin
        if (status.rem_zero || (status.rem_one && status.out_free)) begin
          state_next = S_BADV;
        end
      end
      S_BADV:    state_next = S_COLLECT;
      S_COLLECT: state_next = S_END;
      S_GROUP: begin
        if (!status.group_hit || status.out_free) state_next = S_END;
      end
      S_MIN: begin
        if (!status.cond_min || status.out_free) state_next = S_END;
      end
      S_END: begin
        if (!(status.eot && status.flush_wanted && status.nonempty) || status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.emit = EMIT_NONE;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_DECIDE: begin
        unique case (status.mode)
          MODE_FIXED_SEG: begin
            cmd.collect   = status.d_zero;
            cmd.div_start = !status.d_zero;
          end
          MODE_HIT_COUNT: cmd.collect = 1'b1;
          MODE_MAX_DX: begin
            // threshold reached: emit the collected hits, or pass an empty segment
            if (status.cond_max && status.nonempty) begin
              if (status.out_free) begin
                cmd.emit       = EMIT_GROUP;
                cmd.emit_last  = !status.flush_wanted;
                cmd.sd_add_len = 1'b1;
                cmd.clear      = 1'b1;
              end
            end else if (status.cond_max) begin
              cmd.sd_add_seg = 1'b1;
            end
          end
          MODE_MIN_DX:    cmd.collect = 1'b1;
          default:        cmd.collect = 1'b0;
        endcase
      end
      S_DIV: begin
        cmd.collect = 1'b0;
      end
      S_BOUND: begin
        if (!status.rem_zero && status.out_free) begin
          cmd.emit      = EMIT_BOUNDARY;
          cmd.emit_last = status.rem_one && !status.flush_wanted;
        end
      end
      S_BADV: begin
        cmd.sd_add_adv = status.cross_nz;
        cmd.clear      = status.cross_nz;
      end
      S_COLLECT: begin
        cmd.collect = 1'b1;
      end
      S_GROUP: begin
        if (status.group_hit && status.out_free) begin
          cmd.emit      = EMIT_GROUP;
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
        end
      end
      S_MIN: begin
        if (status.cond_min && status.out_free) begin
          cmd.emit       = EMIT_GROUP;
          cmd.emit_last  = 1'b1;
          cmd.sd_add_len = 1'b1;
          cmd.clear      = 1'b1;
        end
      end
      S_END: begin
        if (status.eot) begin
          if (status.flush_wanted && status.nonempty) begin
            if (status.out_free) begin
              cmd.emit      = EMIT_FLUSH;
              cmd.emit_last = 1'b1;
              cmd.end_clear = 1'b1;
            end
          end else begin
            cmd.end_clear = 1'b1;
          end
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/tsm_checker.sv @@
// Port-level checks for the merger and their bind to the top level.
`default_nettype none

module tsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [1:0]  m_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A flush result closes the run of its item
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("flush result not last");

  // Truncation is only reported on the last result
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("truncated flag on non-last result");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

endmodule

bind track_hit_segment_merger tsm_checker u_tsm_checker (.*);

`default_nettype wire
